// File: src/dfr_pkg.sv
// Package for the delimited frame receiver.
// Holds the frame marks, the type length table types, the control state enum
// and the cell control struct. No dependencies.
`default_nettype none

package dfr_pkg;

    // Frame marks and frame layout
    localparam logic [7:0] START_MARK  = 8'h3C;
    localparam logic [7:0] END_MARK    = 8'h3E;
    localparam logic [2:0] HEADER_LEN  = 3'd3;
    localparam logic [2:0] TYPE_COUNT  = 3'd5;
    localparam logic [2:0] MAX_PAYLOAD = 3'd4;
    localparam int         PAYLOAD_LANES = 4;

    // Cells the controller looks at: start, type, code, four payload bytes, end
    localparam int HEAD_CELLS = 8;

    // One 3-bit length per type code, type 0 in the lowest slot
    typedef logic [4:0][2:0] t_len_array;

    localparam t_len_array LEN_RESET = {3'd4, 3'd4, 3'd2, 3'd1, 3'd0};

    typedef logic [HEAD_CELLS-1:0][7:0] t_head;

    // Control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP,
        ST_SEARCH
    } t_state;

    // Broadcast control for the cell chain
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: src/dfr_cell.sv
// One byte cell of the frame store chain.
// Loads the received byte when selected, or takes its right neighbor's byte
// on a shift. Depends on dfr_pkg.
`default_nettype none

module dfr_cell
    import dfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_sel,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_next_byte,
    output logic      [7:0] o_byte
);

    logic [7:0] r_byte;

    // Shift toward cell 0, or append at the fill position
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_next_byte;
        end else if (i_ctrl.load && i_sel) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// File: src/dfr_ctrl.sv
// Frame controller for the delimited frame receiver.
// Tracks the fill count, judges frames from the first eight cells, drives
// shifts of the cell chain and holds the result register. Depends on dfr_pkg.
`default_nettype none

module dfr_ctrl
    import dfr_pkg::*;
#(
    parameter int STORE_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [7:0]                       i_rx_byte,
    input  wire t_len_array                       i_lengths,
    input  wire t_head                            i_head,
    output t_cell_ctrl                            o_ctrl,
    output logic [$clog2(STORE_DEPTH)-1:0]        o_load_pos,
    output logic [$clog2(STORE_DEPTH+1)-1:0]      o_fill,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [7:0]                            o_msg_code,
    output logic [2:0]                            o_type_code,
    output logic [31:0]                           o_payload_word,
    output logic [2:0]                            o_payload_count
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);

    t_state      r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_msg, n_msg;
    logic [2:0]  r_type, n_type;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_count, n_count;

    logic [FW-1:0] w_eff_fill;
    logic [7:0]    w_type_byte;
    logic          w_type_ok;
    logic [2:0]    w_type_idx;
    logic [2:0]    w_len_raw;
    logic [2:0]    w_len;
    logic [2:0]    w_end_idx;
    logic [FW-1:0] w_need_fill;
    logic [31:0]   w_word;
    logic          w_out_free;

    // A full store is emptied before the next byte is taken
    assign w_eff_fill = (r_fill == FW'(STORE_DEPTH)) ? '0 : r_fill;
    assign o_load_pos = w_eff_fill[IW-1:0];

    // Frame decode from the head cells
    assign w_type_byte = i_head[1];
    assign w_type_ok   = (w_type_byte < {5'd0, TYPE_COUNT});
    assign w_type_idx  = w_type_ok ? w_type_byte[2:0] : 3'd0;
    assign w_len_raw   = i_lengths[w_type_idx];
    assign w_len       = (w_len_raw > MAX_PAYLOAD) ? MAX_PAYLOAD : w_len_raw;
    assign w_end_idx   = w_len + HEADER_LEN;
    assign w_need_fill = FW'(w_end_idx) + FW'(1);
    assign w_out_free  = !r_out_valid || i_ready;

    // Payload lanes, unused lanes zero
    always_comb begin
        for (int i = 0; i < PAYLOAD_LANES; i++) begin
            w_word[8*i +: 8] = (3'(i) < w_len) ? i_head[3 + i] : 8'h00;
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg   <= n_msg;
        r_type  <= n_type;
        r_word  <= n_word;
        r_count <= n_count;
    end

    // Next state, chain control and result capture
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_msg       = r_msg;
        n_type      = r_type;
        n_word      = r_word;
        n_count     = r_count;
        o_ctrl      = '0;
        o_ready     = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (w_eff_fill == '0 && i_rx_byte != START_MARK) begin
                        n_fill = '0;
                    end else begin
                        o_ctrl.load = 1'b1;
                        n_fill      = w_eff_fill + FW'(1);
                        if (i_rx_byte == END_MARK) begin
                            n_state = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (!w_type_ok) begin
                    // unknown type clears the store
                    n_fill  = '0;
                    n_state = ST_IDLE;
                end else if (r_fill < w_need_fill) begin
                    // short frame: the end mark stays as payload
                    n_state = ST_IDLE;
                end else if (i_head[w_end_idx] == END_MARK) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_msg       = i_head[2];
                        n_type      = w_type_idx;
                        n_word      = w_word;
                        n_count     = w_len;
                        n_cnt       = 4'(w_end_idx) + 4'd1;
                        n_state     = ST_DROP;
                    end
                end else begin
                    // bad end: drop the first byte, then hunt for a start mark
                    o_ctrl.shift = 1'b1;
                    n_fill       = r_fill - FW'(1);
                    n_state      = ST_SEARCH;
                end
            end
            ST_DROP: begin
                o_ctrl.shift = 1'b1;
                n_fill       = r_fill - FW'(1);
                n_cnt        = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (r_fill == '0 || i_head[0] == START_MARK) begin
                    n_state = ST_IDLE;
                end else begin
                    o_ctrl.shift = 1'b1;
                    n_fill       = r_fill - FW'(1);
                end
            end
        endcase
    end

    assign o_fill          = r_fill;
    assign o_valid         = r_out_valid;
    assign o_msg_code      = r_msg;
    assign o_type_code     = r_type;
    assign o_payload_word  = r_word;
    assign o_payload_count = r_count;

endmodule

`default_nettype wire

// File: src/delimited_frame_receiver.sv
// Delimited frame receiver: finds '<' type code payload '>' frames in a byte stream.
// Result: an end mark leads to the check state, which registers the result once the result slot is free.
// Throughput: one byte a cycle while idle; after an end mark the check state, then drop
// cycles after a good frame, or search cycles for a start mark after a bad end, paced by
// the one-cell-per-cycle shift; a check waits while a result is held.
// Reset (synchronous, active low) empties the store and restores the length table.
`default_nettype none

module delimited_frame_receiver
    import dfr_pkg::*;
#(
    parameter int STORE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_msg_code,
    output logic [2:0]       o_type_code,
    output logic [31:0]      o_payload_word,
    output logic [2:0]       o_payload_count,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);

    t_len_array    r_len;
    t_cell_ctrl    w_ctrl;
    logic [IW-1:0] w_load_pos;
    logic [FW-1:0] w_fill;
    logic [7:0]    w_bytes [STORE_DEPTH];
    t_head         w_head;

    // Length registers; writes beyond the table are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_we && i_cfg_index < TYPE_COUNT) begin
            r_len[i_cfg_index] <= i_cfg_data;
        end
    end

    // Byte chain, cell 0 holds the oldest byte
    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
        logic [7:0] w_next;
        if (k == STORE_DEPTH - 1) begin : g_last
            assign w_next = 8'h00;
        end else begin : g_mid
            assign w_next = w_bytes[k + 1];
        end
        dfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_sel       (w_load_pos == IW'(k)),
            .i_rx_byte   (i_rx_byte),
            .i_next_byte (w_next),
            .o_byte      (w_bytes[k])
        );
    end

    for (genvar h = 0; h < HEAD_CELLS; h++) begin : g_head
        assign w_head[h] = w_bytes[h];
    end

    dfr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_lengths       (r_len),
        .i_head          (w_head),
        .o_ctrl          (w_ctrl),
        .o_load_pos      (w_load_pos),
        .o_fill          (w_fill),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_msg_code      (o_msg_code),
        .o_type_code     (o_type_code),
        .o_payload_word  (o_payload_word),
        .o_payload_count (o_payload_count)
    );

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= FW'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_plain_byte_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_rx_byte != END_MARK) |=> o_ready)
        else $error("receiver stalled after a byte other than the end mark");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_payload_count <= MAX_PAYLOAD && o_type_code < TYPE_COUNT))
        else $error("result count or type out of range");

    a_top_lane_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_count < MAX_PAYLOAD) |-> (o_payload_word[31:24] == 8'h00))
        else $error("unused payload lane not zero");

endmodule

`default_nettype wire
